// ===== hdl/wfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wfsm_pkg
// Shared constants, codes and elaboration-time table functions for the
// windowed frame spectrum magnitude block.
// ----------------------------------------------------------------------------
package wfsm_pkg;

    localparam int FRAME_LEN_DEF   = 256;
    localparam int BINS_PER_RESULT = 4;
    localparam int SAMPLE_W        = 16;
    localparam int MAG_W           = 24;
    localparam int FRAME_NO_W      = 16;
    localparam int BIN_NO_W        = 8;
    localparam int BVALID_W        = 3;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int STRIDE_W        = 13;
    localparam int WIN_W           = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_STRIDE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FRAMES   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TYPE  = 2'd2;

    localparam logic [WIN_W-1:0] WIN_NONE     = 3'd0;
    localparam logic [WIN_W-1:0] WIN_HANN     = 3'd1;
    localparam logic [WIN_W-1:0] WIN_BLACKMAN = 3'd2;
    localparam logic [WIN_W-1:0] WIN_HAMMING  = 3'd3;
    localparam logic [WIN_W-1:0] WIN_BARTLETT = 3'd4;

    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          BLACK_A     = 64'sd13763;
    localparam longint          BLACK_C     = 64'sd2621;
    localparam longint          HAMM_A      = 64'sd17695;
    localparam longint          HAMM_B      = 64'sd15073;

    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        int              i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint cos_quarter(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned prod;
        longint          t;
        longint          q;
        int              i;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (i = 0; i < 6; i++) begin
            if (t < 0) begin
                t = 0;
            end
            prod = (x2 * longint'(t)) >> 30;
            unique case (i)
                0:       q = longint'(prod / 132);
                1:       q = longint'(prod / 90);
                2:       q = longint'(prod / 56);
                3:       q = longint'(prod / 30);
                4:       q = longint'(prod / 12);
                default: q = longint'(prod / 2);
            endcase
            t = Q30_ONE - q;
        end
        if (t < 0) begin
            t = 0;
        end
        if (t > Q30_ONE) begin
            t = Q30_ONE;
        end
        return t;
    endfunction

    function automatic logic signed [15:0] q15_cos(logic [31:0] p);
        longint unsigned r;
        longint unsigned c;
        logic            neg;
        r = {34'd0, p[29:0]};
        unique case (p[31:30])
            2'd0:    begin c = cos_quarter(r);                                neg = 1'b0; end
            2'd1:    begin c = cos_quarter(longint'(Q30_ONE) - r);            neg = 1'b1; end
            2'd2:    begin c = cos_quarter(r);                                neg = 1'b1; end
            default: begin c = cos_quarter(longint'(Q30_ONE) - r);            neg = 1'b0; end
        endcase
        c = (c + 64'd16384) >> 15;
        if (c > 64'd32767) begin
            c = 64'd32767;
        end
        return neg ? -16'(c) : 16'(c);
    endfunction

    function automatic longint round_q15(longint acc);
        longint w;
        if (acc < 0) begin
            acc = 0;
        end
        w = (acc + 16384) >>> 15;
        return (w > 32767) ? 64'sd32767 : w;
    endfunction

    function automatic logic [14:0] win_coef(logic [WIN_W-1:0] wt, int unsigned i,
                                             int unsigned n);
        longint unsigned pw;
        logic [31:0]     p;
        longint          c;
        longint          c2;
        longint          d;
        longint          w;
        pw = udiv64(longint'(i) << 32, longint'(n - 1));
        p  = pw[31:0];
        c  = longint'(q15_cos(p));
        c2 = longint'(q15_cos(p << 1));
        if (wt == WIN_BARTLETT) begin
            d = 2 * longint'(i) - longint'(n);
            if (d < 0) begin
                d = -d;
            end
            w = longint'(udiv64((longint'(n) - d) * 32768, longint'(n)));
        end else if (wt == WIN_HANN) begin
            w = (32768 - c) >>> 1;
        end else if (wt == WIN_BLACKMAN) begin
            w = round_q15(BLACK_A * 32768 - 16384 * c + BLACK_C * c2);
        end else if (wt == WIN_HAMMING) begin
            w = round_q15(HAMM_A * 32768 - HAMM_B * c);
        end else begin
            w = 32767;
        end
        if (w > 32767) begin
            w = 32767;
        end
        return w[14:0];
    endfunction

    function automatic logic signed [15:0] tw_cos(int unsigned m, int unsigned n);
        longint unsigned pw;
        pw = udiv64(longint'(m) << 32, longint'(n));
        return q15_cos(pw[31:0]);
    endfunction

    function automatic logic signed [15:0] tw_sin(int unsigned m, int unsigned n);
        longint unsigned pw;
        pw = udiv64(longint'(m) << 32, longint'(n));
        return q15_cos(pw[31:0] - 32'h4000_0000);
    endfunction

endpackage

// ===== hdl/windowed_frame_spectrum_magnitude.sv =====
// ----------------------------------------------------------------------------
// windowed_frame_spectrum_magnitude
// Framed, windowed DFT magnitude of an audio sample stream, up to four bins a beat.
// ----------------------------------------------------------------------------
// Each frame takes a direct DFT (one complex MAC per cycle) over every bin,
// then a 32-step square root for each bin of every result beat.
// Throughput: one frame at a time; samples stall until the last beat of the
// frame has been loaded into the output register.
// Reset: synchronous, active low; clears sample and frame counters and write pointer,
// restores config defaults; memories are not cleared and no clearing pass runs.
module windowed_frame_spectrum_magnitude #(
    parameter int FRAME_LEN = wfsm_pkg::FRAME_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wfsm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [wfsm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // sample[15:0]
    input  logic                               s_axis_tuser,  // first_of_recording
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // frame_number[15:0], first_bin[23:16], mag_a[47:24], mag_b[71:48],
    // mag_c[95:72], mag_d[119:96], bins_valid[122:120], zero[127:123]
    output logic [127:0]                       m_axis_tdata,
    output logic                               m_axis_tlast   // last_of_frame
);

    localparam int AW        = $clog2(FRAME_LEN);
    localparam int NUM_BINS  = FRAME_LEN / 2 + 1;
    localparam int BW        = $clog2(NUM_BINS);
    localparam int NUM_RES   = (NUM_BINS + wfsm_pkg::BINS_PER_RESULT - 1)
                               / wfsm_pkg::BINS_PER_RESULT;
    localparam int RW        = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int LAST_VAL  = NUM_BINS - wfsm_pkg::BINS_PER_RESULT * (NUM_RES - 1);

    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_LEN - 1);
    localparam logic [AW:0]   N_W      = (AW + 1)'(FRAME_LEN);
    localparam logic [BW-1:0] LAST_BIN = BW'(NUM_BINS - 1);
    localparam logic [RW-1:0] LAST_RES = RW'(NUM_RES - 1);

    typedef logic [14:0]        t_win_tab [FRAME_LEN];
    typedef logic signed [15:0] t_tw_tab  [FRAME_LEN];

    function automatic t_win_tab build_win(logic [wfsm_pkg::WIN_W-1:0] wt);
        t_win_tab tab;
        int       i;
        for (i = 0; i < FRAME_LEN; i++) begin
            tab[i] = wfsm_pkg::win_coef(wt, i, FRAME_LEN);
        end
        return tab;
    endfunction

    function automatic t_tw_tab build_tw(logic is_sin);
        t_tw_tab tab;
        int      i;
        for (i = 0; i < FRAME_LEN; i++) begin
            tab[i] = is_sin ? wfsm_pkg::tw_sin(i, FRAME_LEN) : wfsm_pkg::tw_cos(i, FRAME_LEN);
        end
        return tab;
    endfunction

    localparam t_win_tab HANN_TAB  = build_win(wfsm_pkg::WIN_HANN);
    localparam t_win_tab BLACK_TAB = build_win(wfsm_pkg::WIN_BLACKMAN);
    localparam t_win_tab HAMM_TAB  = build_win(wfsm_pkg::WIN_HAMMING);
    localparam t_win_tab BART_TAB  = build_win(wfsm_pkg::WIN_BARTLETT);
    localparam t_tw_tab  COS_TAB   = build_tw(1'b0);
    localparam t_tw_tab  SIN_TAB   = build_tw(1'b1);

    typedef enum logic [3:0] {
        S_IDLE, S_RUN, S_DRAIN, S_RND, S_WRITE,
        S_O_INIT, S_O_READ, S_O_ABS, S_O_SQ, S_O_SUM, S_O_ROOT, S_O_STORE, S_O_SEND
    } t_state;

    t_state                           r_state;
    logic [wfsm_pkg::STRIDE_W-1:0]    r_stride;
    logic [15:0]                      r_max_frames;
    logic [wfsm_pkg::WIN_W-1:0]       r_window_type;
    logic [wfsm_pkg::WIN_W-1:0]       r_wtype_f;
    logic [31:0]                      r_seen;
    logic [31:0]                      r_next_end;
    logic [15:0]                      r_frames_done;
    logic [15:0]                      r_frame_no;
    logic [AW-1:0]                    r_wp;
    logic [AW-1:0]                    r_rd_pos;
    logic [AW-1:0]                    r_j;
    logic [AW-1:0]                    r_m;
    logic [BW-1:0]                    r_k;
    logic [RW-1:0]                    r_res;
    logic [BW-1:0]                    r_first;
    logic [BW-1:0]                    r_obin;
    logic [1:0]                       r_b;
    logic [2:0]                       r_bval;
    logic [4:0]                       r_cnt;

    logic signed [15:0]               r_hist_mem [FRAME_LEN];
    logic signed [15:0]               r_hist_q;
    logic [79:0]                      r_work_mem [NUM_BINS];
    logic [79:0]                      r_work_q;

    logic                             r_v1, r_v2, r_v3;
    logic [14:0]                      r_coef1;
    logic signed [15:0]               r_cos1, r_sin1, r_cos2, r_sin2;
    logic signed [30:0]               r_x2;
    logic signed [45:0]               r_pc3, r_ps3;
    logic signed [53:0]               r_acc_re, r_acc_im;
    logic [31:0]                      r_q_re, r_q_im;
    logic                             r_neg_re, r_neg_im;

    logic [31:0]                      r_abs_a, r_abs_b;
    logic [63:0]                      r_sq_a, r_sq_b;
    logic [63:0]                      r_sq_v, r_sq_res, r_sq_bit;
    logic [wfsm_pkg::MAG_W-1:0]       r_mag [wfsm_pkg::BINS_PER_RESULT];

    logic                             r_out_valid;
    logic [15:0]                      r_o_frame;
    logic [7:0]                       r_o_first;
    logic [wfsm_pkg::MAG_W-1:0]       r_o_mag [wfsm_pkg::BINS_PER_RESULT];
    logic [2:0]                       r_o_bval;
    logic                             r_o_last;

    logic                             accept;
    logic [31:0]                      n_seen, n_end_base, stride_eff;
    logic [15:0]                      n_fd_base;
    logic                             hit;
    logic [AW-1:0]                    n_wp;
    logic [AW:0]                      n_m_sum;
    logic signed [31:0]               win_prod;
    logic [53:0]                      abs_re, abs_im, rnd_re, rnd_im;
    logic signed [32:0]               re_q8, im_q8;
    logic signed [32:0]               rd_re, rd_im;
    logic [63:0]                      n_sum;
    logic                             sq_ge;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign n_seen     = (s_axis_tuser ? 32'd0 : r_seen) + 32'd1;
    assign n_end_base = s_axis_tuser ? 32'(FRAME_LEN) : r_next_end;
    assign n_fd_base  = s_axis_tuser ? 16'd0 : r_frames_done;
    assign hit        = (n_seen == n_end_base);
    assign stride_eff = (r_stride == '0) ? 32'd1 : {19'd0, r_stride};
    assign n_wp       = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign n_m_sum    = {1'b0, r_m} + (AW + 1)'(r_k);

    assign win_prod   = r_hist_q * $signed({1'b0, r_coef1});

    assign abs_re     = r_acc_re[53] ? 54'(-r_acc_re) : 54'(r_acc_re);
    assign abs_im     = r_acc_im[53] ? 54'(-r_acc_im) : 54'(r_acc_im);
    assign rnd_re     = abs_re + 54'(1 << 21);
    assign rnd_im     = abs_im + 54'(1 << 21);
    assign re_q8      = r_neg_re ? -$signed({1'b0, r_q_re}) : $signed({1'b0, r_q_re});
    assign im_q8      = r_neg_im ? -$signed({1'b0, r_q_im}) : $signed({1'b0, r_q_im});

    assign rd_re      = r_work_q[72:40];
    assign rd_im      = r_work_q[32:0];

    assign n_sum      = r_sq_res + r_sq_bit;
    assign sq_ge      = (r_sq_v >= n_sum);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist_mem[r_wp] <= $signed(s_axis_tdata);
        end
        r_hist_q <= r_hist_mem[r_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_work_mem[r_k] <= {40'(re_q8), 40'(im_q8)};
        end
        r_work_q <= r_work_mem[r_obin];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        unique case (r_wtype_f)
            wfsm_pkg::WIN_HANN:     r_coef1 <= HANN_TAB[r_j];
            wfsm_pkg::WIN_BLACKMAN: r_coef1 <= BLACK_TAB[r_j];
            wfsm_pkg::WIN_HAMMING:  r_coef1 <= HAMM_TAB[r_j];
            wfsm_pkg::WIN_BARTLETT: r_coef1 <= BART_TAB[r_j];
            default:                r_coef1 <= '0;
        endcase
        r_cos1 <= COS_TAB[r_m];
        r_sin1 <= SIN_TAB[r_m];
        if (r_wtype_f == wfsm_pkg::WIN_NONE || r_wtype_f > wfsm_pkg::WIN_BARTLETT) begin
            r_x2 <= {r_hist_q, 15'd0};
        end else begin
            r_x2 <= win_prod[30:0];
        end
        r_cos2 <= r_cos1;
        r_sin2 <= r_sin1;
        r_pc3  <= 46'(r_x2 * r_cos2);
        r_ps3  <= 46'(r_x2 * r_sin2);
        if (r_state == S_RUN && r_j == '0) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + 54'(r_pc3);
            r_acc_im <= r_acc_im - 54'(r_ps3);
        end
        r_q_re   <= rnd_re[53:22];
        r_q_im   <= rnd_im[53:22];
        r_neg_re <= r_acc_re[53];
        r_neg_im <= r_acc_im[53];
        r_abs_a  <= rd_re[32] ? 32'(-rd_re) : rd_re[31:0];
        r_abs_b  <= rd_im[32] ? 32'(-rd_im) : rd_im[31:0];
        r_sq_a   <= r_abs_a * r_abs_a;
        r_sq_b   <= r_abs_b * r_abs_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_stride      <= 13'd128;
            r_max_frames  <= 16'hFFFF;
            r_window_type <= wfsm_pkg::WIN_NONE;
            r_wtype_f     <= wfsm_pkg::WIN_NONE;
            r_seen        <= '0;
            r_next_end    <= 32'(FRAME_LEN);
            r_frames_done <= '0;
            r_wp          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    wfsm_pkg::CFG_FRAME_STRIDE: r_stride      <= i_cfg_data[12:0];
                    wfsm_pkg::CFG_MAX_FRAMES:   r_max_frames  <= i_cfg_data;
                    wfsm_pkg::CFG_WINDOW_TYPE:  r_window_type <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_wp          <= n_wp;
                        r_seen        <= n_seen;
                        r_next_end    <= hit ? n_end_base + stride_eff : n_end_base;
                        r_frames_done <= n_fd_base;
                        if (hit && n_fd_base < r_max_frames) begin
                            r_frames_done <= n_fd_base + 16'd1;
                            r_frame_no    <= n_fd_base;
                            r_wtype_f     <= r_window_type;
                            r_k           <= '0;
                            r_j           <= '0;
                            r_m           <= '0;
                            r_rd_pos      <= n_wp;
                            r_state       <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_rd_pos <= (r_rd_pos == LAST_IDX) ? '0 : r_rd_pos + 1'b1;
                    r_j      <= r_j + 1'b1;
                    r_m      <= (n_m_sum >= N_W) ? AW'(n_m_sum - N_W) : n_m_sum[AW-1:0];
                    if (r_j == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_j      <= '0;
                    r_m      <= '0;
                    r_rd_pos <= r_wp;
                    if (r_k == LAST_BIN) begin
                        r_res   <= '0;
                        r_first <= '0;
                        r_obin  <= '0;
                        r_state <= S_O_INIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_O_INIT: begin
                    for (int i = 0; i < wfsm_pkg::BINS_PER_RESULT; i++) begin
                        r_mag[i] <= '0;
                    end
                    r_b     <= '0;
                    r_bval  <= (r_res == LAST_RES) ? 3'(LAST_VAL) : 3'(wfsm_pkg::BINS_PER_RESULT);
                    r_state <= S_O_READ;
                end
                S_O_READ: begin
                    r_state <= S_O_ABS;
                end
                S_O_ABS: begin
                    r_state <= S_O_SQ;
                end
                S_O_SQ: begin
                    r_state <= S_O_SUM;
                end
                S_O_SUM: begin
                    r_sq_v   <= r_sq_a + r_sq_b;
                    r_sq_res <= '0;
                    r_sq_bit <= 64'h4000_0000_0000_0000;
                    r_cnt    <= '0;
                    r_state  <= S_O_ROOT;
                end
                S_O_ROOT: begin
                    if (sq_ge) begin
                        r_sq_v   <= r_sq_v - n_sum;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_O_STORE;
                    end
                end
                S_O_STORE: begin
                    r_mag[r_b] <= (r_sq_res[63:32] != '0) ? '1 : r_sq_res[31:8];
                    if (3'(r_b) == r_bval - 3'd1) begin
                        r_state <= S_O_SEND;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_obin  <= r_obin + 1'b1;
                        r_state <= S_O_READ;
                    end
                end
                S_O_SEND: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_o_frame   <= r_frame_no;
                        r_o_first   <= 8'(r_first);
                        r_o_mag     <= r_mag;
                        r_o_bval    <= r_bval;
                        r_o_last    <= (r_res == LAST_RES);
                        if (r_res == LAST_RES) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_res   <= r_res + 1'b1;
                            r_first <= r_first + BW'(wfsm_pkg::BINS_PER_RESULT);
                            r_obin  <= r_first + BW'(wfsm_pkg::BINS_PER_RESULT);
                            r_state <= S_O_INIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {5'd0, r_o_bval, r_o_mag[3], r_o_mag[2], r_o_mag[1], r_o_mag[0],
                            r_o_first, r_o_frame};

endmodule
